@@ hdl/assert_macros.svh @@
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/fcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

  localparam int unsigned TimeW   = 24;
  localparam int unsigned DivW    = 13;
  localparam int unsigned PeriodW = 15;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 4;

  localparam logic [PeriodW-1:0] PeriodMin   = 15'd5;
  localparam logic [PeriodW-1:0] PeriodRst   = 15'd125;
  localparam logic [DivW-1:0]    DivideRst   = 13'd1;
  localparam logic [ValueW-1:0]  OutValueRst = 16'd1;
  // a divide write must leave at least this many ms per sub-interval
  localparam int unsigned        DivFactor   = 5;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_DIVIDE = 2'd1,
    REG_VALUE  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_ENABLE = 1'b1
  } cmd_e;

  typedef enum logic {
    PORT_TICK = 1'b0,
    PORT_TOCK = 1'b1
  } port_e;

  typedef struct packed {
    logic              valid;
    logic [TimeW-1:0]  dividend;
    logic [DivW-1:0]   divisor;
    logic              restart;
  } div_req_t;

  typedef struct packed {
    logic              valid;
    logic [TimeW-1:0]  quotient;
    logic [DivW-1:0]   remainder;
    logic              restart;
  } div_res_t;

endpackage

`default_nettype wire

@@ hdl/fcd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fcd_in_if;
  logic valid;
  logic ready;
  logic command;
  logic enable_level;

  modport source (output valid, output command, output enable_level, input ready);
  modport sink (input valid, input command, input enable_level, output ready);
endinterface

interface fcd_out_if;
  logic               valid;
  logic               ready;
  logic               port;
  logic signed [15:0] value;

  modport source (output valid, output port, output value, input ready);
  modport sink (input valid, input port, input value, output ready);
endinterface

`default_nettype wire

@@ hdl/fcd_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fcd_div import fcd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_res_t      res_o,
  output logic          busy_o
);

  localparam int unsigned Steps = TimeW;

  logic [Steps:0]   vld_q;
  logic [Steps:0]   tag_q;
  logic [DivW-1:0]  dsr_q  [Steps+1];
  logic [DivW-1:0]  rem_q  [Steps+1];
  logic [TimeW-1:0] word_q [Steps+1];

  logic [DivW-1:0]  rem_d  [Steps];
  logic [TimeW-1:0] word_d [Steps];

  // one restoring step per stage, dividend bits shift out as quotient bits shift in
  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [DivW:0] trial;
    logic [DivW:0] diff;
    logic          ge;
    always_comb begin
      trial     = {rem_q[k], word_q[k][TimeW-1]};
      diff      = trial - {1'b0, dsr_q[k]};
      ge        = trial >= {1'b0, dsr_q[k]};
      rem_d[k]  = ge ? diff[DivW-1:0] : trial[DivW-1:0];
      word_d[k] = {word_q[k][TimeW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Steps-1:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q     <= {tag_q[Steps-1:0], req_i.restart};
    dsr_q[0]  <= req_i.divisor;
    rem_q[0]  <= '0;
    word_q[0] <= req_i.dividend;
    for (int k = 0; k < Steps; k++) begin
      dsr_q[k+1]  <= dsr_q[k];
      rem_q[k+1]  <= rem_d[k];
      word_q[k+1] <= word_d[k];
    end
  end

  assign busy_o          = |vld_q;
  assign res_o.valid     = vld_q[Steps];
  assign res_o.quotient  = word_q[Steps];
  assign res_o.remainder = rem_q[Steps];
  assign res_o.restart   = tag_q[Steps];

  `ASSERT_IMPL(a_rem_below_divisor, res_o.valid, res_o.remainder < dsr_q[Steps], "remainder not below divisor")

endmodule

`default_nettype wire

@@ hdl/fractional_clock_divider_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// fractional clock divider
// in_i carries one word per command: command 0 is one base clock tick, command 1
// sets the enable level from enable_level. out_o carries a word for every tick
// (port 0, full period done or divider just enabled) or tock (port 1, end of a
// sub-interval), with the value register copied into it.
// a word that produces a result shows it on out_o in the cycle after it is accepted.
// throughput: one word per cycle while in_i.ready is high; a result waiting in
// the output register is replaced in the same cycle it is taken.
// a write to period_ms or divide_count recomputes quotient and remainder in a
// 24-stage divider pipeline; in_i.ready stays low until it drains.
// when out_o stalls with a result held, in_i.ready drops until it is taken.
// reset: disabled, period 125 ms, one sub-interval, value 1, no result pending.
// apb: register i at byte address 4*i, pready tied high, no wait states.
module fractional_clock_divider_core import fcd_pkg::*; #(
  parameter int unsigned TICKS_PER_MS = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  fcd_in_if.sink                in_i,
  fcd_out_if.source             out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  localparam logic [TimeW-1:0] Tpm     = TimeW'(TICKS_PER_MS);
  localparam logic [TimeW-1:0] TickRst = TimeW'(int'(PeriodRst) * TICKS_PER_MS);

  // configuration
  logic [PeriodW-1:0] period_q, period_d;
  logic [DivW-1:0]    divide_q, divide_d;
  logic [ValueW-1:0]  value_q, value_d;
  logic [TimeW-1:0]   tick_len_q, tick_len_d;

  // phase state
  logic               enabled_q, enabled_d;
  logic [TimeW-1:0]   sub_quot_q, sub_quot_d;
  logic [DivW-1:0]    sub_rem_q, sub_rem_d;
  logic [TimeW-1:0]   interval_q, interval_d;
  logic [TimeW-1:0]   countdown_q, countdown_d;
  logic [TimeW-1:0]   elapsed_q, elapsed_d;
  logic [TimeW-1:0]   rem_acc_q, rem_acc_d;

  // output register
  logic               out_vld_q, out_vld_d;
  logic               out_port_q, out_port_d;
  logic [ValueW-1:0]  out_val_q, out_val_d;

  div_req_t           div_req;
  div_res_t           div_res;
  logic               div_busy;

  logic               in_acc;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;
  logic               emit;
  port_e              emit_port;

  logic [PeriodW-1:0] wr_period;
  logic [DivW-1:0]    wr_divide;
  logic [TimeW-1:0]   rsum;
  logic               roundup;
  logic [TimeW-1:0]   elap_sum;
  logic               full;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_e'(paddr[AddrW-1:2]);
  assign in_i.ready = !div_busy && (!out_vld_q || out_o.ready);
  assign in_acc    = in_i.valid && in_i.ready;

  fcd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res),
    .busy_o (div_busy)
  );

  always_comb begin
    case (cfg_idx)
      REG_PERIOD: prdata = DataW'(period_q);
      REG_DIVIDE: prdata = DataW'(divide_q);
      REG_VALUE:  prdata = DataW'(value_q);
      default:    prdata = '0;
    endcase
  end

  // end-of-sub-interval arithmetic
  always_comb begin
    rsum     = rem_acc_q + TimeW'(sub_rem_q);
    roundup  = rsum >= TimeW'(divide_q);
    elap_sum = elapsed_q + interval_q;
    full     = ({1'b0, elap_sum} + (TimeW+1)'(roundup)) >= {1'b0, tick_len_q};
  end

  // configuration writes and divider launch
  always_comb begin
    period_d   = period_q;
    divide_d   = divide_q;
    value_d    = value_q;
    tick_len_d = tick_len_q;
    div_req    = '0;
    wr_period  = pwdata[PeriodW-1:0];
    wr_divide  = pwdata[DivW-1:0];
    if (wr_period < PeriodMin) begin
      wr_period = PeriodMin;
    end
    if (cfg_wr) begin
      case (cfg_idx)
        REG_PERIOD: begin
          period_d         = wr_period;
          tick_len_d       = TimeW'(wr_period) * Tpm;
          div_req.valid    = 1'b1;
          div_req.dividend = tick_len_d;
          div_req.divisor  = divide_q;
          div_req.restart  = 1'b1;
        end
        REG_DIVIDE: begin
          if (wr_divide == '0) begin
            divide_d = DivideRst;
          end else if ((18'(wr_divide) * 18'(DivFactor)) <= 18'(period_q)) begin
            divide_d = wr_divide;
          end
          div_req.valid    = 1'b1;
          div_req.dividend = tick_len_q;
          div_req.divisor  = divide_d;
          div_req.restart  = 1'b0;
        end
        REG_VALUE: begin
          value_d = pwdata[ValueW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // phase state next value
  always_comb begin
    enabled_d   = enabled_q;
    sub_quot_d  = sub_quot_q;
    sub_rem_d   = sub_rem_q;
    interval_d  = interval_q;
    countdown_d = countdown_q;
    elapsed_d   = elapsed_q;
    rem_acc_d   = rem_acc_q;
    emit        = 1'b0;
    emit_port   = PORT_TICK;
    if (div_res.valid) begin
      sub_quot_d = div_res.quotient;
      sub_rem_d  = div_res.remainder;
      if (div_res.restart) begin
        interval_d  = div_res.quotient;
        countdown_d = div_res.quotient;
        elapsed_d   = '0;
        rem_acc_d   = '0;
      end
    end
    if (in_acc) begin
      if (in_i.command == CMD_ENABLE) begin
        if (in_i.enable_level) begin
          if (!enabled_q) begin
            enabled_d   = 1'b1;
            interval_d  = sub_quot_q;
            countdown_d = sub_quot_q;
            elapsed_d   = '0;
            rem_acc_d   = '0;
            emit        = 1'b1;
            emit_port   = PORT_TICK;
          end
        end else begin
          enabled_d = 1'b0;
        end
      end else if (enabled_q) begin
        if (countdown_q > TimeW'(1)) begin
          countdown_d = countdown_q - TimeW'(1);
        end else begin
          interval_d  = sub_quot_q + TimeW'(roundup);
          countdown_d = interval_d;
          emit        = 1'b1;
          if (full) begin
            elapsed_d = '0;
            rem_acc_d = '0;
            emit_port = PORT_TICK;
          end else begin
            elapsed_d = elap_sum;
            rem_acc_d = roundup ? rsum - TimeW'(divide_q) : rsum;
            emit_port = PORT_TOCK;
          end
        end
      end
    end
  end

  // output register, refilled in the cycle it is taken
  always_comb begin
    out_vld_d  = out_vld_q;
    out_port_d = out_port_q;
    out_val_d  = out_val_q;
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (emit) begin
      out_vld_d  = 1'b1;
      out_port_d = emit_port;
      out_val_d  = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PeriodRst;
      divide_q    <= DivideRst;
      value_q     <= OutValueRst;
      tick_len_q  <= TickRst;
      enabled_q   <= 1'b0;
      sub_quot_q  <= TickRst;
      sub_rem_q   <= '0;
      interval_q  <= '0;
      countdown_q <= '0;
      elapsed_q   <= '0;
      rem_acc_q   <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      period_q    <= period_d;
      divide_q    <= divide_d;
      value_q     <= value_d;
      tick_len_q  <= tick_len_d;
      enabled_q   <= enabled_d;
      sub_quot_q  <= sub_quot_d;
      sub_rem_q   <= sub_rem_d;
      interval_q  <= interval_d;
      countdown_q <= countdown_d;
      elapsed_q   <= elapsed_d;
      rem_acc_q   <= rem_acc_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_port_q <= out_port_d;
    out_val_q  <= out_val_d;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.port  = out_port_q;
  assign out_o.value = out_val_q;

  `ASSERT_IMPL(a_div_blocks_input, div_res.valid, !$past(in_i.ready), "word accepted while divider ran")
  `ASSERT_NEXT(a_enable_ticks, in_acc && in_i.command == CMD_ENABLE && in_i.enable_level && !enabled_q, out_vld_q && out_port_q == PORT_TICK, "enable gave no tick")
  `ASSERT_IMPL(a_disable_cause, $fell(enabled_q), $past(in_acc) && $past(in_i.command) == CMD_ENABLE && !$past(in_i.enable_level), "divider disabled without command")

endmodule

`default_nettype wire

@@ tb/sv/fractional_clock_divider_core_tb.sv @@
`timescale 1ns / 1ps

module fractional_clock_divider_core_tb;
  import fcd_pkg::*;

  localparam int unsigned TICKS_PER_MS  = 1;
  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned RANDOM_ITEMS  = 1900;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  // no register behind this index, writes must be dropped
  localparam logic [1:0]  REG_SPARE     = 2'd3;

  class pulse_tracker;
    typedef struct packed {
      port_e             port;
      logic [ValueW-1:0] value;
    } pulse_t;

    pulse_t             pending[$];
    int unsigned        mismatches;

    logic [PeriodW-1:0] period_ms;
    logic [DivW-1:0]    divide;
    logic [ValueW-1:0]  out_value;

    bit                 enabled;
    logic [TimeW-1:0]   tick_length;
    logic [TimeW-1:0]   sub_q;
    logic [TimeW-1:0]   sub_r;
    logic [TimeW-1:0]   interval_len;
    logic [TimeW-1:0]   countdown;
    logic [TimeW-1:0]   elapsed;
    logic [TimeW-1:0]   rem_accum;

    function new();
      mismatches   = 0;
      period_ms    = PeriodRst;
      divide       = DivideRst;
      out_value    = OutValueRst;
      enabled      = 1'b0;
      retime();
      interval_len = '0;
      countdown    = '0;
      elapsed      = '0;
      rem_accum    = '0;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void retime();
      tick_length = TimeW'(32'(period_ms) * TICKS_PER_MS);
      sub_q       = tick_length / TimeW'(divide);
      sub_r       = tick_length % TimeW'(divide);
    endfunction

    function void restart();
      interval_len = sub_q;
      countdown    = sub_q;
      elapsed      = '0;
      rem_accum    = '0;
    endfunction

    function void emit(port_e port);
      pulse_t p;
      p.port  = port;
      p.value = out_value;
      pending.push_back(p);
    endfunction

    function void write_reg(logic [1:0] idx, logic [DataW-1:0] data);
      logic [PeriodW-1:0] p;
      logic [DivW-1:0]    d;
      p = data[PeriodW-1:0];
      d = data[DivW-1:0];
      case (idx)
        REG_PERIOD: begin
          period_ms = (p < PeriodMin) ? PeriodMin : p;
          retime();
          restart();
        end
        REG_DIVIDE: begin
          if (d == '0) begin
            divide = 13'd1;
          end else if (32'(d) * DivFactor <= 32'(period_ms)) begin
            divide = d;
          end
          retime();
        end
        REG_VALUE: begin
          out_value = data[ValueW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // one accepted command word; queues the tick or tock it causes
    function void take_command(cmd_e cmd, logic level);
      bit roundup;
      roundup = 1'b0;
      if (cmd == CMD_ENABLE) begin
        if (level) begin
          if (!enabled) begin
            enabled = 1'b1;
            restart();
            emit(PORT_TICK);
          end
        end else begin
          enabled = 1'b0;
        end
        return;
      end
      if (!enabled) return;
      if (countdown > 1) begin
        countdown = countdown - 1'b1;
        return;
      end
      // sub-interval over, spread the remainder bresenham style
      elapsed      = elapsed + interval_len;
      rem_accum    = rem_accum + sub_r;
      interval_len = sub_q;
      if (rem_accum >= TimeW'(divide)) begin
        rem_accum    = rem_accum - TimeW'(divide);
        interval_len = interval_len + 1'b1;
        roundup      = 1'b1;
      end
      countdown = interval_len;
      if ({1'b0, elapsed} + roundup >= {1'b0, tick_length}) begin
        elapsed   = '0;
        rem_accum = '0;
        emit(PORT_TICK);
      end else begin
        emit(PORT_TOCK);
      end
    endfunction

    task check_pulse(port_e port, logic [ValueW-1:0] value);
      pulse_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word port %0d value %0d", port, $signed(value)));
        return;
      end
      e = pending.pop_front();
      if (port != e.port) begin
        report($sformatf("port %0d, expected %0d", port, e.port));
      end
      if (value != e.value) begin
        report($sformatf("value %0d, expected %0d", $signed(value), $signed(e.value)));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  fcd_in_if  cmd_ch ();
  fcd_out_if pulse_ch ();

  pulse_tracker tracker = new();

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_left;
  int unsigned cycle_count;

  fractional_clock_divider_core #(
    .TICKS_PER_MS(TICKS_PER_MS)
  ) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_ch),
    .out_o  (pulse_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** fractional_clock_divider_core: FAILED **");
    $finish;
  end

  // result side: checks every taken word, stalls at random or for a long hold
  initial begin
    forever begin
      @(posedge clk);
      if (pulse_ch.valid && pulse_ch.ready) begin
        tracker.check_pulse(port_e'(pulse_ch.port), pulse_ch.value);
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        pulse_ch.ready <= 1'b0;
      end else begin
        pulse_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_word(input cmd_e cmd, input logic level);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.command      <= cmd;
    cmd_ch.enable_level <= level;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    tracker.take_command(cmd, level);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(idx, data);
    @(posedge clk);
  endtask

  // quiet the input and let every expected word come out before a write
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned drain;
    int unsigned p;
    int unsigned eff;
    int unsigned d;
    int unsigned pick;
    bit          squeezed;
    cmd_e        cmd;
    logic        level;
    logic [15:0] v;

    sent     = 0;
    squeezed = 1'b0;
    hold_left      = 0;
    src_idle_pct   = 15;
    sink_stall_pct = 84;
    rst_n               <= 1'b0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.command      <= CMD_TICK;
    cmd_ch.enable_level <= 1'b0;
    pulse_ch.ready      <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clamped period and divide, dropped divide, spare register
    write_reg(REG_PERIOD, 32'd0);
    write_reg(REG_DIVIDE, 32'd0);
    write_reg(REG_DIVIDE, 32'd2);
    write_reg(REG_VALUE, 32'h0000_8000);
    write_reg(REG_SPARE, 32'hffff_ffff);
    send_word(CMD_TICK, 1'b1);
    send_word(CMD_ENABLE, 1'b0);
    send_word(CMD_ENABLE, 1'b1);
    send_word(CMD_ENABLE, 1'b1);
    repeat (5) send_word(CMD_TICK, 1'b0);
    send_word(CMD_ENABLE, 1'b0);
    send_word(CMD_TICK, 1'b0);
    send_word(CMD_ENABLE, 1'b1);
    settle();

    write_reg(REG_PERIOD, 32'd32767);
    write_reg(REG_DIVIDE, 32'd6553);
    write_reg(REG_VALUE, 32'h0000_7fff);
    repeat (7) send_word(CMD_TICK, 1'b0);
    settle();

    // period shrinks under a stale divide: zero-length sub-intervals
    write_reg(REG_PERIOD, 32'd100);
    write_reg(REG_DIVIDE, 32'd20);
    write_reg(REG_PERIOD, 32'd7);
    write_reg(REG_VALUE, 32'd0);
    send_word(CMD_ENABLE, 1'b0);
    send_word(CMD_ENABLE, 1'b1);
    repeat (4) send_word(CMD_TICK, 1'b0);

    while (sent < RANDOM_ITEMS) begin
      case (sent * 3 / RANDOM_ITEMS)
        0: begin
          src_idle_pct   = 15;
          sink_stall_pct = 84;
        end
        1: begin
          src_idle_pct   = 84;
          sink_stall_pct = 15;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      settle();

      pick = $urandom_range(9);
      if (src_idle_pct == 0 && !squeezed) begin
        p = 5;
        d = 1;
      end else if (pick == 0) begin
        // long period, sub-intervals kept short so words still come
        p   = ($urandom_range(1) != 0) ? 32767 : $urandom_range(32767, 100);
        eff = p / DivFactor;
        d   = eff - $urandom_range(3);
      end else begin
        p   = $urandom_range(60);
        eff = (p < PeriodMin) ? PeriodMin : p;
        if (pick == 1) begin
          d = 0;
        end else if (pick == 2) begin
          d = eff / DivFactor + 1 + $urandom_range(8);
        end else begin
          d = $urandom_range(eff / DivFactor, 1);
        end
      end
      if ($urandom_range(3) == 0) begin
        write_reg(REG_DIVIDE, d);
        write_reg(REG_PERIOD, p);
      end else begin
        write_reg(REG_PERIOD, p);
        write_reg(REG_DIVIDE, d);
      end
      case ($urandom_range(7))
        0: v = 16'h8000;
        1: v = 16'h7fff;
        2: v = 16'hffff;
        3: v = 16'h0000;
        default: v = 16'($urandom_range(65535));
      endcase
      write_reg(REG_VALUE, {16'h0000, v});
      if ($urandom_range(9) == 0) begin
        write_reg(REG_SPARE, $urandom);
      end

      len = $urandom_range(160, 40);
      if (src_idle_pct == 0 && !squeezed) begin
        // output held off while commands keep coming, input must back up
        squeezed  = 1'b1;
        hold_left = HOLD_CYCLES;
        len       = 160;
      end
      send_word(CMD_ENABLE, 1'b1);
      sent++;
      repeat (len) begin
        if ($urandom_range(99) < 8) begin
          cmd   = CMD_ENABLE;
          level = ($urandom_range(99) < 65);
        end else begin
          cmd   = CMD_TICK;
          level = $urandom_range(1);
        end
        send_word(cmd, level);
        sent++;
      end
    end

    cmd_ch.valid <= 1'b0;
    drain = 0;
    while (tracker.pending.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending.size() != 0) begin
      tracker.report($sformatf("%0d words never arrived", tracker.pending.size()));
    end
    if (tracker.mismatches == 0) begin
      $display("** fractional_clock_divider_core: PASSED **");
    end else begin
      $display("** fractional_clock_divider_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ fractional_clock_divider_core.f @@
+incdir+hdl
hdl/fcd_pkg.sv
hdl/fcd_if.sv
hdl/fcd_div.sv
hdl/fractional_clock_divider_core.sv
tb/sv/fractional_clock_divider_core_tb.sv
